@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the RTL top level, socks5_request_parser.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

@@ hw/rtl/s5rp_pkg.sv @@
// Types and constants for the SOCKS5 request parser.
// Used by s5rp_step and socks5_request_parser; no dependencies.
package s5rp_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_MORE  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  // Sticky error kinds
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_VERSION  = 3'd1,
    ERR_RESERVED = 3'd2,
    ERR_TYPE     = 3'd3,
    ERR_ZERO_LEN = 3'd4
  } err_e;

  // Internal address type codes
  typedef enum logic [1:0] {
    TYPE_IPV4   = 2'd0,
    TYPE_DOMAIN = 2'd1,
    TYPE_IPV6   = 2'd2
  } atyp_e;

  // Wire-format constants
  localparam logic [7:0] SOCKS_VERSION = 8'h05;
  localparam logic [7:0] RSV_BYTE      = 8'h00;
  localparam logic [7:0] WIRE_IPV4     = 8'h01;
  localparam logic [7:0] WIRE_DOMAIN   = 8'h03;
  localparam logic [7:0] WIRE_IPV6     = 8'h04;
  localparam logic [7:0] IPV4_LEN      = 8'd4;
  localparam logic [7:0] IPV6_LEN      = 8'd16;

  // Byte positions within a request
  localparam int unsigned PosW = 9;
  localparam logic [PosW-1:0] POS_VERSION = 9'd0;
  localparam logic [PosW-1:0] POS_CMD     = 9'd1;
  localparam logic [PosW-1:0] POS_RSV     = 9'd2;
  localparam logic [PosW-1:0] POS_ATYP    = 9'd3;
  localparam logic [PosW-1:0] POS_ADDR    = 9'd4;
  localparam logic [PosW-1:0] POS_DADDR   = 9'd5;
  // Last position: domain of 255 bytes, plus two port bytes
  localparam logic [PosW-1:0] POS_MAX     = 9'd261;

  // Parser state carried between bytes
  typedef struct packed {
    logic [PosW-1:0] pos;
    atyp_e           atyp;
    logic [7:0]      cmd;
    logic [7:0]      dlen;
    logic [7:0]      port_hi;
    err_e            err;
  } state_t;

  // One result item
  typedef struct packed {
    status_e    status;
    err_e       error_kind;
    logic       addr_valid;
    logic [7:0] addr_index;
    logic [7:0] addr_byte;
    logic [7:0] command;
    atyp_e      addr_type;
    logic [7:0] addr_count;
    logic [15:0] dest_port;
  } result_t;

endpackage

@@ hw/rtl/socks5_request_parser.sv @@
// SOCKS5 request parser top level: handshake, state and result registers.
// Depends on s5rp_pkg, s5rp_step and assert_macros.svh.
//
// Parses a SOCKS5 connection request one byte per transfer and returns one
// result per byte. A byte is taken every cycle while the result register is
// empty or being drained in the same cycle, so throughput is one byte per
// clock into a registered result; the only loop is the parse state register
// feeding the per-byte decode. Address bytes are passed out with their index,
// the final port byte reports the full request, and any error is held until
// reset.
`include "assert_macros.svh"

module socks5_request_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [2:0]  error_kind_o,
  output logic        addr_valid_o,
  output logic [7:0]  addr_index_o,
  output logic [7:0]  addr_byte_o,
  output logic [7:0]  command_o,
  output logic [1:0]  addr_type_o,
  output logic [7:0]  addr_count_o,
  output logic [15:0] dest_port_o
);

  s5rp_pkg::state_t  state_q, state_d;
  s5rp_pkg::result_t res_q, res_d;
  logic              out_valid_q;
  logic              in_xfer;

  // Accept while the result slot is free or emptying this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  s5rp_step u_step (
    .state_i  (state_q),
    .byte_i   (in_byte_i),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = res_q.status;
  assign error_kind_o = res_q.error_kind;
  assign addr_valid_o = res_q.addr_valid;
  assign addr_index_o = res_q.addr_index;
  assign addr_byte_o  = res_q.addr_byte;
  assign command_o    = res_q.command;
  assign addr_type_o  = res_q.addr_type;
  assign addr_count_o = res_q.addr_count;
  assign dest_port_o  = res_q.dest_port;

  // Checks
  `ASSERT_AT(a_err_sticky, clk_i, rst_ni,
    (state_q.err != s5rp_pkg::ERR_NONE) |=> (state_q.err == $past(state_q.err)),
    "held error changed")
  `ASSERT_AT(a_err_status, clk_i, rst_ni,
    out_valid_q |-> ((res_q.status == s5rp_pkg::ST_ERROR) == (res_q.error_kind != s5rp_pkg::ERR_NONE)),
    "error kind and status disagree")
  `ASSERT_AT(a_addr_more, clk_i, rst_ni,
    (out_valid_q && res_q.addr_valid) |-> (res_q.status == s5rp_pkg::ST_MORE),
    "address byte with non-more status")
  `ASSERT_NEVER(a_pos_range, clk_i, rst_ni,
    (state_q.pos > s5rp_pkg::POS_MAX),
    "byte position out of range")

endmodule

@@ hw/rtl/s5rp_step.sv @@
// Per-byte parse logic: next parser state and the result for one byte.
// Depends on s5rp_pkg.
module s5rp_step (
  input  s5rp_pkg::state_t  state_i,
  input  logic [7:0]        byte_i,
  output s5rp_pkg::state_t  state_o,
  output s5rp_pkg::result_t result_o
);

  logic                          is_domain;
  logic [s5rp_pkg::PosW-1:0]     base;
  logic [7:0]                    alen;
  logic [s5rp_pkg::PosW-1:0]     lim;
  logic [s5rp_pkg::PosW-1:0]     idx_full;
  logic [s5rp_pkg::PosW-1:0]     pos_inc;

  // Address span for the held type
  assign is_domain = (state_i.atyp == s5rp_pkg::TYPE_DOMAIN);
  assign base      = is_domain ? s5rp_pkg::POS_DADDR : s5rp_pkg::POS_ADDR;
  assign alen      = is_domain ? state_i.dlen :
                     ((state_i.atyp == s5rp_pkg::TYPE_IPV4) ? s5rp_pkg::IPV4_LEN
                                                            : s5rp_pkg::IPV6_LEN);
  assign lim       = base + {1'b0, alen};
  assign idx_full  = state_i.pos - base;
  assign pos_inc   = state_i.pos + 9'd1;

  // Field decode and state update
  always_comb begin
    state_o           = state_i;
    result_o          = '0;
    result_o.status   = s5rp_pkg::ST_MORE;
    if (state_i.err == s5rp_pkg::ERR_NONE) begin
      case (state_i.pos)
        s5rp_pkg::POS_VERSION: begin
          if (byte_i != s5rp_pkg::SOCKS_VERSION) state_o.err = s5rp_pkg::ERR_VERSION;
          else                                   state_o.pos = s5rp_pkg::POS_CMD;
        end
        s5rp_pkg::POS_CMD: begin
          state_o.cmd = byte_i;
          state_o.pos = s5rp_pkg::POS_RSV;
        end
        s5rp_pkg::POS_RSV: begin
          if (byte_i != s5rp_pkg::RSV_BYTE) state_o.err = s5rp_pkg::ERR_RESERVED;
          else                              state_o.pos = s5rp_pkg::POS_ATYP;
        end
        s5rp_pkg::POS_ATYP: begin
          case (byte_i)
            s5rp_pkg::WIRE_IPV4: begin
              state_o.atyp = s5rp_pkg::TYPE_IPV4;
              state_o.pos  = s5rp_pkg::POS_ADDR;
            end
            s5rp_pkg::WIRE_DOMAIN: begin
              state_o.atyp = s5rp_pkg::TYPE_DOMAIN;
              state_o.pos  = s5rp_pkg::POS_ADDR;
            end
            s5rp_pkg::WIRE_IPV6: begin
              state_o.atyp = s5rp_pkg::TYPE_IPV6;
              state_o.pos  = s5rp_pkg::POS_ADDR;
            end
            default: state_o.err = s5rp_pkg::ERR_TYPE;
          endcase
        end
        default: begin
          if (is_domain && (state_i.pos == s5rp_pkg::POS_ADDR)) begin
            // Domain length byte
            if (byte_i == 8'd0) begin
              state_o.err = s5rp_pkg::ERR_ZERO_LEN;
            end else begin
              state_o.dlen = byte_i;
              state_o.pos  = s5rp_pkg::POS_DADDR;
            end
          end else if (state_i.pos < lim) begin
            result_o.addr_valid = 1'b1;
            result_o.addr_index = idx_full[7:0];
            result_o.addr_byte  = byte_i;
            state_o.pos         = pos_inc;
          end else if (state_i.pos == lim) begin
            state_o.port_hi = byte_i;
            state_o.pos     = pos_inc;
          end else begin
            // Low port byte: request complete, rearm
            result_o.status     = s5rp_pkg::ST_DONE;
            result_o.command    = state_i.cmd;
            result_o.addr_type  = state_i.atyp;
            result_o.addr_count = alen;
            result_o.dest_port  = {state_i.port_hi, byte_i};
            state_o.pos         = s5rp_pkg::POS_VERSION;
          end
        end
      endcase
    end

    // Any held error overrides the result
    if (state_o.err != s5rp_pkg::ERR_NONE) begin
      result_o            = '0;
      result_o.status     = s5rp_pkg::ST_ERROR;
      result_o.error_kind = state_o.err;
    end
  end

endmodule

@@ tb/tb_socks5_request_parser.sv @@
`timescale 1ns / 1ps
// Testbench for socks5_request_parser: streams SOCKS5 requests byte by byte
// and checks every per-byte result against a parse model kept in the bench.
// Depends on s5rp_pkg and the socks5_request_parser RTL.
module tb_socks5_request_parser;

  localparam int unsigned StreamLen  = 900;
  localparam int unsigned NoiseLen   = 30;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned TailCycles = 10;

  // One pending request byte; drain holds it back until all results are in
  typedef struct {
    logic [7:0] data;
    bit         drain;
  } stream_item_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i   = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [2:0]  error_kind_o;
  logic        addr_valid_o;
  logic [7:0]  addr_index_o;
  logic [7:0]  addr_byte_o;
  logic [7:0]  command_o;
  logic [1:0]  addr_type_o;
  logic [7:0]  addr_count_o;
  logic [15:0] dest_port_o;

  stream_item_t        stream_q[$];
  s5rp_pkg::result_t   byte_results_q[$];
  int unsigned  mismatches  = 0;
  int unsigned  idle_cycles = 0;
  bit           in_fire     = 1'b0;
  bit           out_fire    = 1'b0;
  int unsigned  in_gap      = 0;
  int unsigned  out_stall   = 0;
  bit           in_calm     = 1'b0;
  bit           out_calm    = 1'b1;

  // Parser state as the bench sees it
  logic [8:0]      parse_pos  = '0;
  s5rp_pkg::atyp_e parse_atyp = s5rp_pkg::TYPE_IPV4;
  logic [7:0]      parse_cmd  = '0;
  logic [7:0]      parse_dlen = '0;
  logic [7:0]      parse_phi  = '0;
  s5rp_pkg::err_e  parse_err  = s5rp_pkg::ERR_NONE;

  socks5_request_parser u_top (.*);

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Expected result for one byte; advances the parse state
  function automatic s5rp_pkg::result_t parse_byte(input logic [7:0] b);
    s5rp_pkg::result_t r;
    int unsigned pos;
    int unsigned base;
    int unsigned alen;
    r = '0;
    r.status = s5rp_pkg::ST_MORE;
    pos = parse_pos;
    if (parse_err == s5rp_pkg::ERR_NONE) begin
      if (parse_pos == s5rp_pkg::POS_VERSION) begin
        if (b != s5rp_pkg::SOCKS_VERSION) parse_err = s5rp_pkg::ERR_VERSION;
        else parse_pos = s5rp_pkg::POS_CMD;
      end else if (parse_pos == s5rp_pkg::POS_CMD) begin
        parse_cmd = b;
        parse_pos = s5rp_pkg::POS_RSV;
      end else if (parse_pos == s5rp_pkg::POS_RSV) begin
        if (b != s5rp_pkg::RSV_BYTE) parse_err = s5rp_pkg::ERR_RESERVED;
        else parse_pos = s5rp_pkg::POS_ATYP;
      end else if (parse_pos == s5rp_pkg::POS_ATYP) begin
        case (b)
          s5rp_pkg::WIRE_IPV4: begin
            parse_atyp = s5rp_pkg::TYPE_IPV4;
            parse_pos  = s5rp_pkg::POS_ADDR;
          end
          s5rp_pkg::WIRE_DOMAIN: begin
            parse_atyp = s5rp_pkg::TYPE_DOMAIN;
            parse_pos  = s5rp_pkg::POS_ADDR;
          end
          s5rp_pkg::WIRE_IPV6: begin
            parse_atyp = s5rp_pkg::TYPE_IPV6;
            parse_pos  = s5rp_pkg::POS_ADDR;
          end
          default: parse_err = s5rp_pkg::ERR_TYPE;
        endcase
      end else if (parse_atyp == s5rp_pkg::TYPE_DOMAIN &&
                   parse_pos == s5rp_pkg::POS_ADDR) begin
        // domain length byte
        if (b == 8'h00) begin
          parse_err = s5rp_pkg::ERR_ZERO_LEN;
        end else begin
          parse_dlen = b;
          parse_pos  = s5rp_pkg::POS_DADDR;
        end
      end else begin
        base = (parse_atyp == s5rp_pkg::TYPE_DOMAIN) ? s5rp_pkg::POS_DADDR
                                                     : s5rp_pkg::POS_ADDR;
        alen = (parse_atyp == s5rp_pkg::TYPE_DOMAIN) ? parse_dlen :
               (parse_atyp == s5rp_pkg::TYPE_IPV4) ? s5rp_pkg::IPV4_LEN
                                                   : s5rp_pkg::IPV6_LEN;
        if (pos < base + alen) begin
          r.addr_valid = 1'b1;
          r.addr_index = 8'(pos - base);
          r.addr_byte  = b;
          parse_pos    = parse_pos + 9'd1;
        end else if (pos == base + alen) begin
          parse_phi = b;
          parse_pos = parse_pos + 9'd1;
        end else begin
          r.status     = s5rp_pkg::ST_DONE;
          r.command    = parse_cmd;
          r.addr_type  = parse_atyp;
          r.addr_count = 8'(alen);
          r.dest_port  = {parse_phi, b};
          parse_pos    = '0;
        end
      end
    end
    // held error masks everything else
    if (parse_err != s5rp_pkg::ERR_NONE) begin
      r = '0;
      r.status = s5rp_pkg::ST_ERROR;
      r.error_kind = parse_err;
    end
    return r;
  endfunction

  // Wait before the next transfer; calm stretches have no waits at all
  function automatic int unsigned draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic void push_byte(input logic [7:0] data, input bit drain);
    stream_q.push_back('{data: data, drain: drain});
  endfunction

  // Well-formed request; pattern gives alternating 00/FF address bytes
  task automatic push_request(input logic [7:0] atyp_code, input int unsigned dom_len,
                              input logic [7:0] cmd, input logic [15:0] port,
                              input bit pattern, input bit drain);
    int unsigned n;
    n = (atyp_code == s5rp_pkg::WIRE_IPV4) ? s5rp_pkg::IPV4_LEN :
        (atyp_code == s5rp_pkg::WIRE_IPV6) ? s5rp_pkg::IPV6_LEN : dom_len;
    push_byte(s5rp_pkg::SOCKS_VERSION, drain);
    push_byte(cmd, 1'b0);
    push_byte(s5rp_pkg::RSV_BYTE, 1'b0);
    push_byte(atyp_code, 1'b0);
    if (atyp_code == s5rp_pkg::WIRE_DOMAIN) push_byte(8'(dom_len), 1'b0);
    for (int i = 0; i < n; i++) begin
      push_byte(pattern ? ((i % 2 == 1) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255)), 1'b0);
    end
    push_byte(port[15:8], 1'b0);
    push_byte(port[7:0], 1'b0);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Byte driver: new byte at the falling edge once the previous one transferred
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap--;
      end else if (stream_q.size() > 0 &&
                   !(stream_q[0].drain && byte_results_q.size() > 0)) begin
        in_byte_i  <= stream_q[0].data;
        in_valid_i <= 1'b1;
        void'(stream_q.pop_front());
        in_gap = draw_wait(in_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result sink: random stall after each result transfer
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire) out_stall = draw_wait(out_calm);
      if (out_stall > 0) begin
        out_ready_i <= 1'b0;
        out_stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor: compare results first, then queue the prediction for a new byte
  always @(posedge clk_i) begin
    s5rp_pkg::result_t want;
    in_fire  = rst_ni && in_valid_i && in_ready_o;
    out_fire = rst_ni && out_valid_o && out_ready_i;
    if (out_fire) begin
      if (byte_results_q.size() == 0) begin
        $error("result transfer with no byte outstanding");
        mismatches++;
      end else begin
        want = byte_results_q.pop_front();
        check_field("status", want.status, status_o);
        check_field("error_kind", want.error_kind, error_kind_o);
        check_field("addr_valid", want.addr_valid, addr_valid_o);
        check_field("addr_index", want.addr_index, addr_index_o);
        check_field("addr_byte", want.addr_byte, addr_byte_o);
        check_field("command", want.command, command_o);
        check_field("addr_type", want.addr_type, addr_type_o);
        check_field("addr_count", want.addr_count, addr_count_o);
        check_field("dest_port", want.dest_port, dest_port_o);
      end
    end
    if (in_fire) byte_results_q.push_back(parse_byte(in_byte_i));
    idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
  end

  // Stall detector
  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned    sel;
    logic [7:0]     atyp_code;
    logic [7:0]     b;
    s5rp_pkg::err_e pick;
    bit             first;

    // Directed: IPv4 with 00/FF address, command 0, port FFFF;
    // shortest domain, command FF, port 0
    push_request(s5rp_pkg::WIRE_IPV4, 0, 8'h00, 16'hFFFF, 1'b1, 1'b0);
    push_request(s5rp_pkg::WIRE_DOMAIN, 1, 8'hFF, 16'h0000, 1'b1, 1'b0);

    // Random well-formed requests, a few with the longest domain
    first = 1'b1;
    while (stream_q.size() < StreamLen) begin
      sel = $urandom_range(0, 9);
      atyp_code = (sel < 4) ? s5rp_pkg::WIRE_IPV4 :
                  (sel < 7) ? s5rp_pkg::WIRE_DOMAIN : s5rp_pkg::WIRE_IPV6;
      push_request(atyp_code,
                   ($urandom_range(0, 24) == 0) ? 255 : $urandom_range(1, 20),
                   8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                   1'b0, first || $urandom_range(0, 14) == 0);
      first = 1'b0;
    end

    // Errors stick until reset, so a single broken request ends the stream
    pick = s5rp_pkg::err_e'($urandom_range(1, 4));
    case (pick)
      s5rp_pkg::ERR_VERSION: begin
        do b = 8'($urandom_range(0, 255)); while (b == s5rp_pkg::SOCKS_VERSION);
        push_byte(b, 1'b1);
      end
      s5rp_pkg::ERR_RESERVED: begin
        push_byte(s5rp_pkg::SOCKS_VERSION, 1'b1);
        push_byte(8'($urandom_range(0, 255)), 1'b0);
        push_byte(8'($urandom_range(1, 255)), 1'b0);
      end
      s5rp_pkg::ERR_TYPE: begin
        push_byte(s5rp_pkg::SOCKS_VERSION, 1'b1);
        push_byte(8'($urandom_range(0, 255)), 1'b0);
        push_byte(s5rp_pkg::RSV_BYTE, 1'b0);
        do b = 8'($urandom_range(0, 255));
        while (b == s5rp_pkg::WIRE_IPV4 || b == s5rp_pkg::WIRE_DOMAIN ||
               b == s5rp_pkg::WIRE_IPV6);
        push_byte(b, 1'b0);
      end
      default: begin
        push_byte(s5rp_pkg::SOCKS_VERSION, 1'b1);
        push_byte(8'($urandom_range(0, 255)), 1'b0);
        push_byte(s5rp_pkg::RSV_BYTE, 1'b0);
        push_byte(s5rp_pkg::WIRE_DOMAIN, 1'b0);
        push_byte(8'h00, 1'b0);
      end
    endcase
    // noise after the error, all of it ignored
    for (int i = 0; i < NoiseLen; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (stream_q.size() > 0 || in_valid_i || byte_results_q.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/s5rp_pkg.sv
hw/rtl/s5rp_step.sv
hw/rtl/socks5_request_parser.sv
tb/tb_socks5_request_parser.sv
